### hdl/bmpd_pkg.sv
// Shared types and constants for the BMP stream pixel decoder.
`default_nettype none
package bmpd_pkg;

  localparam int unsigned MaxDimDef = 256;
  localparam int unsigned HdrLen    = 54;

  localparam logic [2:0] ST_PIXEL = 3'd0;
  localparam logic [2:0] ST_SIG   = 3'd1;
  localparam logic [2:0] ST_COMP  = 3'd2;
  localparam logic [2:0] ST_DEPTH = 3'd3;
  localparam logic [2:0] ST_DIM   = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [23:0] color;
    logic [8:0]  image_width;
    logic [8:0]  image_height;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

### hdl/bmpd_front.sv
// Byte parser: header capture and check, offset skip, pixel assembly.
`default_nettype none
module bmpd_front #(
  parameter int unsigned MAX_DIM = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [31:0]   file_length_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_file_i,
  output bmpd_pkg::res_t     res_o,
  output logic               res_valid_o
);
  import bmpd_pkg::*;

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned RowW = DimW + 2;
  localparam int unsigned PrdW = RowW + DimW;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic            magic_q, magic_d;
  logic [31:0]     off_q, off_d, wid_q, wid_d, hgt_q, hgt_d, cmp_q, cmp_d;
  logic [15:0]     dep_q, dep_d;
  logic            top_q, top_d, d32_q, d32_d;
  logic [DimW-1:0] col_q, col_d, rowc_q, rowc_d, imgw_q, imgw_d, imgh_q, imgh_d;
  logic [RowW-1:0] rbc_q, rbc_d, pixb_q, pixb_d, rsz_q, rsz_d;
  logic [1:0]      bip_q, bip_d;
  logic [15:0]     hold_q, hold_d;

  logic [31:0]     hmag;
  logic            dims_ok, dep_ok, chk_setw, too_long;
  logic [DimW-1:0] chk_w, chk_h;
  logic [RowW-1:0] chk_pixb, chk_rsz, rbc_n;
  logic [PrdW-1:0] prod;
  logic [32:0]     need;
  logic [2:0]      chk_st;
  logic [5:0]      pos6;
  logic [1:0]      lane;
  logic            pix_out, pix_last;
  res_t            res;
  logic            rv;

  always_comb begin
    hmag     = hgt_q[31] ? (32'd0 - hgt_q) : hgt_q;
    dims_ok  = !wid_q[31] && (wid_q != 32'd0) && (wid_q <= 32'(MAX_DIM)) &&
               (hmag != 32'd0) && (hmag <= 32'(MAX_DIM));
    dep_ok   = (dep_q == 16'd24) || (dep_q == 16'd32);
    chk_w    = wid_q[DimW-1:0];
    chk_h    = hmag[DimW-1:0];
    chk_pixb = (dep_q == 16'd32) ? {chk_w, 2'b00}
                                 : (RowW'({chk_w, 1'b0}) + RowW'(chk_w));
    chk_rsz  = (chk_pixb + RowW'(3)) & ~RowW'(3);
    prod     = PrdW'(chk_rsz) * PrdW'(chk_h);
    need     = {1'b0, off_q} + 33'(prod);
    too_long = need > {1'b0, file_length_i};
    chk_setw = magic_q && (file_length_i >= 32'(HdrLen)) && (cmp_q == 32'd0) &&
               dep_ok && dims_ok;
    if (!magic_q)                            chk_st = ST_SIG;
    else if (file_length_i < 32'(HdrLen))    chk_st = ST_TRUNC;
    else if (cmp_q != 32'd0)                 chk_st = ST_COMP;
    else if (!dep_ok)                        chk_st = ST_DEPTH;
    else if (!dims_ok)                       chk_st = ST_DIM;
    else if (off_q < 32'(HdrLen))            chk_st = ST_TRUNC;
    else if (too_long)                       chk_st = ST_TRUNC;
    else                                     chk_st = ST_PIXEL;
  end

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; magic_d = magic_q; off_d = off_q;
    wid_d = wid_q; hgt_d = hgt_q; dep_d = dep_q; cmp_d = cmp_q;
    top_d = top_q; d32_d = d32_q; col_d = col_q; rowc_d = rowc_q;
    imgw_d = imgw_q; imgh_d = imgh_q; rbc_d = rbc_q; pixb_d = pixb_q;
    rsz_d = rsz_q; bip_d = bip_q; hold_d = hold_q;
    res = '0; rv = 1'b0; pix_out = 1'b0; pix_last = 1'b0;
    pos6 = pos_q[5:0]; lane = 2'd0; rbc_n = rbc_q + RowW'(1);

    if (accept_i) begin
      pos_d = pos_q + 32'd1;
      case (phase_q)
        PH_HEADER: begin
          if (pos6 == 6'd0 && data_byte_i != 8'h42) magic_d = 1'b0;
          if (pos6 == 6'd1 && data_byte_i != 8'h4d) magic_d = 1'b0;
          if (pos6 inside {[6'd10:6'd13]}) begin
            lane = 2'(pos6 - 6'd10);
            off_d[8*lane +: 8] = data_byte_i;
          end
          if (pos6 inside {[6'd18:6'd21]}) begin
            lane = 2'(pos6 - 6'd18);
            wid_d[8*lane +: 8] = data_byte_i;
          end
          if (pos6 inside {[6'd22:6'd25]}) begin
            lane = 2'(pos6 - 6'd22);
            hgt_d[8*lane +: 8] = data_byte_i;
          end
          if (pos6 inside {[6'd28:6'd29]}) begin
            dep_d[8*pos6[0] +: 8] = data_byte_i;
          end
          if (pos6 inside {[6'd30:6'd33]}) begin
            lane = 2'(pos6 - 6'd30);
            cmp_d[8*lane +: 8] = data_byte_i;
          end
          if (pos6 == 6'(HdrLen - 1)) begin
            top_d = hgt_q[31];
            if (chk_setw) begin
              imgw_d = chk_w;
              imgh_d = chk_h;
              d32_d  = (dep_q == 16'd32);
              pixb_d = chk_pixb;
              rsz_d  = chk_rsz;
            end
            if (chk_st != ST_PIXEL) begin
              rv = 1'b1;
              res.status = chk_st;
              res.last = 1'b1;
              res.image_width  = chk_setw ? 9'(chk_w) : 9'd0;
              res.image_height = chk_setw ? 9'(chk_h) : 9'd0;
              phase_d = PH_DONE;
            end else begin
              phase_d = (off_q == 32'(HdrLen)) ? PH_PIXELS : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (pos_d == off_q) phase_d = PH_PIXELS;
        end
        PH_PIXELS: begin
          if (rbc_q < pixb_q) begin
            case (bip_q)
              2'd0: hold_d = {8'd0, data_byte_i};
              2'd1: hold_d = {data_byte_i, hold_q[7:0]};
              2'd2: begin
                pix_out = 1'b1;
                pix_last = (rowc_q == imgh_q - DimW'(1)) && (col_q == imgw_q - DimW'(1));
                col_d = col_q + DimW'(1);
              end
              default: ;
            endcase
            bip_d = (!d32_q && bip_q == 2'd2) ? 2'd0 : bip_q + 2'd1;
          end
          rbc_d = rbc_n;
          if (rbc_n >= rsz_q) begin
            rbc_d = '0; col_d = '0; bip_d = 2'd0; rowc_d = rowc_q + DimW'(1);
          end
          res.status = ST_PIXEL;
          res.column = 8'(col_q);
          res.row    = top_q ? 8'(rowc_q) : 8'(imgh_q - DimW'(1) - rowc_q);
          res.color  = {data_byte_i, hold_q};
          res.image_width  = 9'(imgw_q);
          res.image_height = 9'(imgh_q);
          res.last   = pix_last;
          if (pix_last) begin
            rv = 1'b1; phase_d = PH_DONE;
          end else if (pix_out && !end_of_file_i) begin
            rv = 1'b1;
          end
        end
        default: ;
      endcase

      if (end_of_file_i) begin
        if (!rv && phase_d != PH_DONE) begin
          rv = 1'b1;
          res = '0;
          res.status = ST_TRUNC;
          res.image_width  = 9'(imgw_d);
          res.image_height = 9'(imgh_d);
          res.last = 1'b1;
        end
        phase_d = PH_HEADER; pos_d = '0; magic_d = 1'b1; off_d = '0; wid_d = '0;
        hgt_d = '0; dep_d = '0; cmp_d = '0; top_d = 1'b0; d32_d = 1'b0;
        col_d = '0; rowc_d = '0; imgw_d = '0; imgh_d = '0; rbc_d = '0;
        pixb_d = '0; rsz_d = '0; bip_d = 2'd0; hold_d = '0;
      end
    end
  end

  assign res_o = res;
  assign res_valid_o = rv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= '0; magic_q <= 1'b1; off_q <= '0; wid_q <= '0;
      hgt_q <= '0; dep_q <= '0; cmp_q <= '0; top_q <= 1'b0; d32_q <= 1'b0;
      col_q <= '0; rowc_q <= '0; imgw_q <= '0; imgh_q <= '0; rbc_q <= '0;
      pixb_q <= '0; rsz_q <= '0; bip_q <= 2'd0; hold_q <= '0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; magic_q <= magic_d; off_q <= off_d;
      wid_q <= wid_d; hgt_q <= hgt_d; dep_q <= dep_d; cmp_q <= cmp_d;
      top_q <= top_d; d32_q <= d32_d; col_q <= col_d; rowc_q <= rowc_d;
      imgw_q <= imgw_d; imgh_q <= imgh_d; rbc_q <= rbc_d; pixb_q <= pixb_d;
      rsz_q <= rsz_d; bip_q <= bip_d; hold_q <= hold_d;
    end
  end

endmodule
`default_nettype wire

### hdl/bmpd_outq.sv
// Two-entry result queue driving the output channel.
`default_nettype none
module bmpd_outq (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  bmpd_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      stall_i,
  output bmpd_pkg::res_t data_o
);
  import bmpd_pkg::*;

  res_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into full queue");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count not advanced");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_q != rd_q)) else $error("pointer mismatch");
`endif

endmodule
`default_nettype wire

### hdl/bmp_stream_pixel_decoder.sv
// Top level of the streaming BMP 24/32-bit pixel decoder.
// A result is registered in the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle unless stalled; the header check, including a small row-size
// by height multiply, is combinational and acts when byte 53 is accepted.
// Input stalls only when the two-entry result queue is full.
// Reset: asynchronous, active low; clears parser state, queue and file_length.
`default_nettype none
module bmp_stream_pixel_decoder #(
  parameter int unsigned MAX_DIM = bmpd_pkg::MaxDimDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       column_o,
  output logic [7:0]       row_o,
  output logic [23:0]      color_o,
  output logic [8:0]       image_width_o,
  output logic [8:0]       image_height_o,
  output logic             last_o
);
  import bmpd_pkg::*;

  logic [31:0] flen_q;
  logic        full, accept, rv;
  res_t        res, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flen_q <= '0;
    else if (cfg_we_i) flen_q <= cfg_data_i;
  end

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  bmpd_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni,
    .file_length_i(flen_q),
    .accept_i(accept),
    .data_byte_i, .end_of_file_i,
    .res_o(res),
    .res_valid_o(rv)
  );

  bmpd_outq u_outq (
    .clk_i, .rst_ni,
    .push_i(rv),
    .push_data_i(res),
    .full_o(full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o(head)
  );

  assign status_o       = head.status;
  assign column_o       = head.column;
  assign row_o          = head.row;
  assign color_o        = head.color;
  assign image_width_o  = head.image_width;
  assign image_height_o = head.image_height;
  assign last_o         = head.last;

endmodule
`default_nettype wire

### verif/bmp_stream_pixel_decoder_test.sv
// Randomized streaming test of the BMP pixel decoder, checked against a built-in predictor.
`default_nettype none
module bmp_stream_pixel_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bmpd_pkg::*;

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_DONE} phase_e;

  class bmp_scoreboard;
    res_t        want_q[$];
    int          errors;
    logic [31:0] file_length;
    phase_e      phase;
    logic [31:0] pos_cnt, pix_off, w_word, h_word, comp_word, img_w, img_h, bpp, row_size;
    logic [15:0] depth_word;
    logic        magic_ok, top_down;
    logic [31:0] col_cnt, row_cnt, row_bytes, byte_in_px;
    logic [15:0] bg_hold;

    function new();
      errors = 0;
      file_length = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_HEADER;
      pos_cnt = 0; magic_ok = 1; pix_off = 0; w_word = 0; h_word = 0;
      depth_word = 0; comp_word = 0; top_down = 0; col_cnt = 0; row_cnt = 0;
      row_bytes = 0; byte_in_px = 0; bg_hold = 0; img_w = 0; img_h = 0;
      bpp = 3; row_size = 0;
    endfunction

    function logic [2:0] header_status();
      logic [31:0] hmag;
      if (!magic_ok) return ST_SIG;
      if (file_length < HdrLen) return ST_TRUNC;
      if (comp_word != 0) return ST_COMP;
      if (depth_word != 24 && depth_word != 32) return ST_DEPTH;
      top_down = h_word[31];
      hmag = h_word[31] ? -h_word : h_word;
      if (w_word[31] || w_word == 0 || w_word > MaxDimDef || hmag == 0 || hmag > MaxDimDef)
        return ST_DIM;
      img_w = w_word;
      img_h = hmag;
      bpp = depth_word / 8;
      row_size = (img_w * bpp + 3) & ~32'd3;
      if (pix_off < HdrLen) return ST_TRUNC;
      if ({32'd0, pix_off} + {32'd0, row_size} * {32'd0, img_h} > {32'd0, file_length})
        return ST_TRUNC;
      return ST_PIXEL;
    endfunction

    function void note_request(logic [7:0] b, logic eof);
      res_t        r;
      logic [31:0] p;
      logic [2:0]  st;
      bit          have, px_out, px_last;
      have = 0; px_out = 0; px_last = 0;
      r = '0;
      p = pos_cnt;
      pos_cnt = p + 1;
      if (phase == PH_HEADER) begin
        if (p == 0 && b != 8'h42) magic_ok = 0;
        if (p == 1 && b != 8'h4D) magic_ok = 0;
        if (p >= 10 && p <= 13) pix_off[(p - 10) * 8 +: 8] = b;
        if (p >= 18 && p <= 21) w_word[(p - 18) * 8 +: 8] = b;
        if (p >= 22 && p <= 25) h_word[(p - 22) * 8 +: 8] = b;
        if (p >= 28 && p <= 29) depth_word[(p - 28) * 8 +: 8] = b;
        if (p >= 30 && p <= 33) comp_word[(p - 30) * 8 +: 8] = b;
        if (p == 53) begin
          st = header_status();
          if (st != ST_PIXEL) begin
            r.status = st;
            r.image_width = (st == ST_TRUNC && img_w != 0) ? img_w[8:0] : '0;
            r.image_height = (st == ST_TRUNC && img_w != 0) ? img_h[8:0] : '0;
            r.last = 1;
            have = 1;
            phase = PH_DONE;
          end else begin
            phase = (pix_off == HdrLen) ? PH_PIXELS : PH_SKIP;
          end
        end
      end else if (phase == PH_SKIP) begin
        if (pos_cnt == pix_off) phase = PH_PIXELS;
      end else if (phase == PH_PIXELS) begin
        if (row_bytes < img_w * bpp) begin
          if (byte_in_px == 0) bg_hold = {8'd0, b};
          else if (byte_in_px == 1) bg_hold = {b, bg_hold[7:0]};
          else if (byte_in_px == 2) begin
            px_out = 1;
            r.status = ST_PIXEL;
            r.column = col_cnt[7:0];
            r.row = top_down ? row_cnt[7:0] : 8'(img_h - 1 - row_cnt);
            r.color = {b, bg_hold};
            r.image_width = img_w[8:0];
            r.image_height = img_h[8:0];
            px_last = (row_cnt == img_h - 1) && (col_cnt == img_w - 1);
            col_cnt++;
          end
          byte_in_px++;
          if (byte_in_px >= bpp) byte_in_px = 0;
        end
        row_bytes++;
        if (row_bytes >= row_size) begin
          row_bytes = 0; col_cnt = 0; byte_in_px = 0;
          row_cnt++;
        end
        if (px_last) begin
          r.last = 1;
          have = 1;
          phase = PH_DONE;
        end else if (px_out && !eof) begin
          have = 1;
        end
      end
      if (eof) begin
        if (!have && phase != PH_DONE) begin
          r = '0;
          r.status = ST_TRUNC;
          r.image_width = img_w[8:0];
          r.image_height = img_h[8:0];
          r.last = 1;
          have = 1;
        end
        clear();
      end
      if (have) want_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(res_t got);
      res_t w;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = want_q.pop_front();
      if (got.status !== w.status)
        report($sformatf("status %0d want %0d", got.status, w.status));
      if (got.column !== w.column)
        report($sformatf("column %0d want %0d", got.column, w.column));
      if (got.row !== w.row) report($sformatf("row %0d want %0d", got.row, w.row));
      if (got.color !== w.color) report($sformatf("color %h want %h", got.color, w.color));
      if (got.image_width !== w.image_width)
        report($sformatf("width %0d want %0d", got.image_width, w.image_width));
      if (got.image_height !== w.image_height)
        report($sformatf("height %0d want %0d", got.image_height, w.image_height));
      if (got.last !== w.last) report($sformatf("last %0d want %0d", got.last, w.last));
    endtask
  endclass

  localparam int MODE_GOOD = 0, MODE_SIG = 1, MODE_COMP = 2, MODE_DEPTH = 3, MODE_DIM = 4,
                 MODE_OFFSET = 5, MODE_SHORT = 6, MODE_EARLY_EOF = 7, MODE_NOISE = 8,
                 MODE_TINY_LEN = 9;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        end_of_file_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  res_t        got;
  bit          calm = 0;
  int          sent = 0;
  bmp_scoreboard sb = new();

  bmp_stream_pixel_decoder uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .data_byte_i, .end_of_file_i, .out_valid_o, .out_stall_i,
    .status_o(got.status), .column_o(got.column), .row_o(got.row), .color_o(got.color),
    .image_width_o(got.image_width), .image_height_o(got.image_height), .last_o(got.last)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(got);
    out_stall_i <= !calm && ($urandom_range(0, 99) < 37);
  end

  task automatic push_byte(logic [7:0] b, logic eof);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    data_byte_i <= b;
    end_of_file_i <= eof;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(b, eof);
    sent++;
  endtask

  task automatic set_length(logic [31:0] v);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.file_length = v;
  endtask

  task automatic run_file(int w, int h, int depth, bit top, int gap, int mode);
    logic [7:0]  f[$];
    logic [31:0] wword, hword, off, comp, flen, body;
    logic [15:0] dep;
    int          rs, stop, i, n;
    wword = w; hword = top ? -h : h; off = HdrLen + gap; comp = 0; dep = depth;
    rs = ((w * depth / 8) + 3) & ~3;
    body = rs * h;
    n = (mode == MODE_NOISE) ? $urandom_range(1, 90) : HdrLen;
    for (i = 0; i < n; i++) f.push_back($urandom);
    if (mode != MODE_NOISE) begin
      case (mode)
        MODE_COMP: comp = ($urandom_range(0, 1)) ? $urandom_range(1, 3) : (32'h1 << $urandom_range(0, 31));
        MODE_DEPTH: dep = ($urandom_range(0, 1)) ? $urandom_range(0, 23) : 16'($urandom);
        MODE_DIM: begin
          case ($urandom_range(0, 5))
            0: wword = 0;
            1: wword = MaxDimDef + 1;
            2: wword = $urandom | 32'h8000_0000;
            3: hword = 0;
            4: hword = 32'h8000_0000;
            default: hword = top ? -(MaxDimDef + 1) : $urandom_range(MaxDimDef + 1, 70000);
          endcase
          body = $urandom_range(0, 20);
        end
        MODE_OFFSET: off = $urandom_range(0, HdrLen - 1);
        default: ;
      endcase
      if (mode == MODE_SIG) begin
        f[0] = 8'h42; f[1] = 8'h4D;
        f[$urandom_range(0, 1)] ^= 8'h1 << $urandom_range(0, 7);
      end else begin
        f[0] = 8'h42; f[1] = 8'h4D;
      end
      for (i = 0; i < 4; i++) begin
        f[10 + i] = off[8 * i +: 8];
        f[18 + i] = wword[8 * i +: 8];
        f[22 + i] = hword[8 * i +: 8];
        f[30 + i] = comp[8 * i +: 8];
      end
      f[28] = dep[7:0]; f[29] = dep[15:8];
      if (mode == MODE_SIG || mode == MODE_COMP || mode == MODE_DEPTH) body = $urandom_range(0, 20);
      for (i = 0; i < gap; i++) f.push_back($urandom);
      for (i = 0; i < body; i++) f.push_back($urandom);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) f.push_back($urandom);
    end
    flen = off + rs * h + $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) flen = 32'hFFFF_FFFF;
    if (mode == MODE_SHORT) flen = off + rs * h - $urandom_range(1, rs * h);
    if (mode == MODE_TINY_LEN) flen = $urandom_range(0, HdrLen - 1);
    if (mode == MODE_NOISE) flen = $urandom;
    stop = (mode == MODE_EARLY_EOF) ? $urandom_range(0, f.size() - 1) : f.size() - 1;
    set_length(flen);
    for (i = 0; i <= stop; i++) push_byte(f[i], i == stop);
  endtask

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int k, m;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    run_file(1, 1, 24, 0, 0, MODE_GOOD);
    run_file(3, 2, 24, 0, 0, MODE_GOOD);
    run_file(3, 2, 32, 1, 0, MODE_GOOD);
    run_file(2, 3, 24, 1, 5, MODE_GOOD);
    run_file(2, 2, 24, 0, 0, MODE_SIG);
    run_file(2, 2, 24, 0, 0, MODE_COMP);
    run_file(2, 2, 24, 0, 0, MODE_DEPTH);
    for (k = 0; k < 2; k++) run_file(2, 2, 24, k[0], 0, MODE_DIM);
    run_file(2, 2, 32, 0, 0, MODE_OFFSET);
    run_file(2, 2, 24, 0, 2, MODE_SHORT);
    run_file(2, 2, 24, 0, 1, MODE_EARLY_EOF);
    run_file(2, 2, 24, 0, 0, MODE_TINY_LEN);
    run_file(1, 1, 24, 0, 0, MODE_NOISE);
    set_length(0);
    push_byte(8'h00, 1);
    set_length(32'hFFFF_FFFF);
    // pause sender until all results drained
    while (sb.want_q.size() != 0) @(posedge clk_i);
    k = sent;
    m = 0;
    while (sent - k < 300) begin
      calm = (m >= 1 && m < 4);
      case ($urandom_range(0, 19))
        0: run_file(2, 2, 24, 0, 0, MODE_SIG);
        1: run_file(2, 2, 24, 0, 0, MODE_COMP);
        2: run_file(2, 2, 24, 0, 0, MODE_DEPTH);
        3: run_file(2, 2, 24, $urandom_range(0, 1), 0, MODE_DIM);
        4: run_file(2, 2, 32, 0, 0, MODE_OFFSET);
        5: run_file($urandom_range(1, 5), $urandom_range(1, 4), 24, 0, 0, MODE_SHORT);
        6, 7: run_file($urandom_range(1, 5), $urandom_range(1, 4), 32, $urandom_range(0, 1),
                       $urandom_range(0, 3), MODE_EARLY_EOF);
        8: run_file(1, 1, 24, 0, 0, MODE_NOISE);
        9: run_file(1, 1, 24, 0, 0, MODE_TINY_LEN);
        10: run_file($urandom_range(0, 1) ? MaxDimDef : $urandom_range(1, 40), 1,
                     $urandom_range(0, 1) ? 24 : 32, $urandom_range(0, 1), 0, MODE_GOOD);
        default: run_file($urandom_range(1, 6), $urandom_range(1, 5),
                          $urandom_range(0, 1) ? 24 : 32, $urandom_range(0, 1),
                          $urandom_range(0, 1) ? 0 : $urandom_range(1, 6), MODE_GOOD);
      endcase
      m++;
    end
    calm = 0;
    in_valid_i <= 0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### bmp_stream_pixel_decoder.f
hdl/bmpd_pkg.sv
hdl/bmpd_front.sv
hdl/bmpd_outq.sv
hdl/bmp_stream_pixel_decoder.sv
verif/bmp_stream_pixel_decoder_test.sv
